/* src/pfd_pkg.sv */
// Shared types and constants for the PPM frame decoder.
// Used by pfd_mem and ppm_frame_decoder; depends on nothing.
package pfd_pkg;

  // Width of one stored or reported pulse value.
  localparam int unsigned DataW = 16;
  // Channel position register: holds a channel, the idle code or the armed code.
  localparam int unsigned PosW = 5;
  localparam logic [PosW-1:0] PosArmed = 5'd31;

  // Configuration port.
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] RegPulseCenter = 2'd0;
  localparam logic [CfgIdxW-1:0] RegUncalChannel = 2'd1;
  localparam logic [DataW-1:0] PulseCenterRst = 16'd1500;
  localparam logic [3:0] UncalChannelRst = 4'd2;

  // Input operation codes.
  localparam logic OpResync = 1'b0;
  localparam logic OpEdge = 1'b1;

endpackage

/* src/ppm_frame_decoder.sv */
// PPM frame decoder top level: control sequencer, datapath and two value stores.
// Depends on pfd_pkg and pfd_mem.
//
// Usage: the input channel takes requests of two kinds. A resync request
// (operation 0) rearms the decoder; the next edge request is discarded and
// each edge after it reports one channel, up to CHANNELS of them. Each
// counted edge gives one result request on the output channel carrying the
// channel index, the averaged pulse value, a frame-done flag on the last
// channel and the calibration status. Resyncs and discarded edges give none.
// Configuration writes (pulse center, uncalibrated channel) are taken at
// any time but are meant for when the decoder is idle.
// A resync or an ignored edge is taken in the idle state. A counted edge
// reads both stores, then computes, writes back and loads the output
// register in a compute state; no new request is taken until it is done.
// After the first complete frame, the copy of values into the offset store
// walks all channels through the store ports before the next request is taken.
// Reset leaves the decoder idle (edges ignored until a resync), both stores
// reading as zero and the configuration at its default values.
// The output register holds one result; while it is full and the receiver
// stalls, the next counted edge waits in its compute cycle.
module ppm_frame_decoder #(
  parameter int unsigned CHANNELS = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [pfd_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [pfd_pkg::DataW-1:0]          cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               operation_i,
  input  logic [15:0]                        interval_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [3:0]                         channel_index_o,
  output logic signed [15:0]                 pulse_value_o,
  output logic                               frame_done_o,
  output logic                               calibrated_o
);

  localparam int unsigned AddrW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [pfd_pkg::PosW-1:0] PosIdle = pfd_pkg::PosW'(CHANNELS);
  localparam logic [pfd_pkg::PosW-1:0] PosLast = pfd_pkg::PosW'(CHANNELS - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CALC = 2'd1;
  localparam logic [1:0] S_COPY = 2'd2;

  logic [1:0] state_q, state_d;
  logic [pfd_pkg::PosW-1:0] pos_q, pos_d;
  logic cal_done_q, cal_done_d;
  logic [pfd_pkg::DataW-1:0] center_q;
  logic [3:0] uncal_q;
  logic [15:0] interval_q;
  logic [pfd_pkg::PosW-1:0] copy_cnt_q, copy_cnt_d;
  logic copy_wv_q, copy_wv_d;
  logic [AddrW-1:0] copy_wa_q, copy_wa_d;

  logic out_valid_q, out_valid_d;
  logic [3:0] out_ch_q;
  logic [15:0] out_val_q;
  logic out_done_q, out_cal_q;

  logic p_we, p_re, o_we, o_re;
  logic [AddrW-1:0] p_waddr, p_raddr, o_waddr, o_raddr;
  logic [pfd_pkg::DataW-1:0] p_wdata, p_rdata, o_rdata;

  logic in_fire, out_load, ch_uncal, last_ch, copy_skip;
  logic [AddrW-1:0] ch_addr;
  logic [15:0] centered, calib, sum, avg;

  pfd_mem #(.Depth(CHANNELS), .AddrW(AddrW)) u_pulse_mem (
    .clk_i, .rst_ni,
    .we_i(p_we), .waddr_i(p_waddr), .wdata_i(p_wdata),
    .re_i(p_re), .raddr_i(p_raddr), .rdata_o(p_rdata)
  );

  pfd_mem #(.Depth(CHANNELS), .AddrW(AddrW)) u_offset_mem (
    .clk_i, .rst_ni,
    .we_i(o_we), .waddr_i(o_waddr), .wdata_i(p_rdata),
    .re_i(o_re), .raddr_i(o_raddr), .rdata_o(o_rdata)
  );

  assign cfg_ready_o = 1'b1;
  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire = in_valid_i && in_ready_o;
  assign ch_addr = pos_q[AddrW-1:0];

  // Datapath: center, calibrate, then average with the stored value.
  // The arithmetic shift rounds down, so a negative sum is bumped by one first to truncate toward zero.
  assign ch_uncal = ({1'b0, uncal_q} == pos_q);
  assign centered = interval_q - center_q;
  assign calib = ch_uncal ? centered : centered - o_rdata;
  assign sum = p_rdata + calib;
  assign avg = 16'($signed(sum + {15'd0, sum[15]}) >>> 1);
  assign last_ch = (pos_q == PosLast);
  assign out_load = (state_q == S_CALC) && (!out_valid_q || out_ready_i);
  assign copy_skip = ({1'b0, uncal_q} == pfd_pkg::PosW'(copy_wa_q));

  always_comb begin
    state_d = state_q;
    pos_d = pos_q;
    cal_done_d = cal_done_q;
    copy_cnt_d = copy_cnt_q;
    copy_wv_d = 1'b0;
    copy_wa_d = copy_wa_q;
    p_we = 1'b0;
    p_waddr = ch_addr;
    p_wdata = avg;
    p_re = 1'b0;
    p_raddr = ch_addr;
    o_re = 1'b0;
    o_raddr = ch_addr;
    o_we = 1'b0;
    o_waddr = copy_wa_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (operation_i == pfd_pkg::OpResync) begin
            pos_d = pfd_pkg::PosArmed;
          end else if (pos_q == pfd_pkg::PosArmed) begin
            pos_d = '0;
          end else if (pos_q < PosIdle) begin
            p_re = 1'b1;
            o_re = 1'b1;
            state_d = S_CALC;
          end
        end
      end
      S_CALC: begin
        if (out_load) begin
          p_we = 1'b1;
          pos_d = pos_q + 1'b1;
          if (last_ch && !cal_done_q) begin
            cal_done_d = 1'b1;
            copy_cnt_d = '0;
            state_d = S_COPY;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_COPY: begin
        // Read channel k from the pulse store while writing channel k-1
        // into the offset store.
        p_raddr = copy_cnt_q[AddrW-1:0];
        if (copy_cnt_q < PosIdle) begin
          p_re = 1'b1;
          copy_wv_d = 1'b1;
          copy_wa_d = copy_cnt_q[AddrW-1:0];
          copy_cnt_d = copy_cnt_q + 1'b1;
        end
        o_we = copy_wv_q && !copy_skip;
        if (copy_cnt_q == PosIdle && copy_wv_q) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pos_q <= PosIdle;
      cal_done_q <= 1'b0;
      copy_cnt_q <= '0;
      copy_wv_q <= 1'b0;
      out_valid_q <= 1'b0;
      center_q <= pfd_pkg::PulseCenterRst;
      uncal_q <= pfd_pkg::UncalChannelRst;
    end else begin
      state_q <= state_d;
      pos_q <= pos_d;
      cal_done_q <= cal_done_d;
      copy_cnt_q <= copy_cnt_d;
      copy_wv_q <= copy_wv_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          pfd_pkg::RegPulseCenter: center_q <= cfg_data_i;
          pfd_pkg::RegUncalChannel: uncal_q <= cfg_data_i[3:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    copy_wa_q <= copy_wa_d;
    if (in_fire) begin
      interval_q <= interval_i;
    end
    if (out_load) begin
      out_ch_q <= pos_q[3:0];
      out_val_q <= avg;
      out_done_q <= last_ch;
      out_cal_q <= cal_done_q || last_ch;
    end
  end

  assign out_valid_o = out_valid_q;
  assign channel_index_o = out_ch_q;
  assign pulse_value_o = $signed(out_val_q);
  assign frame_done_o = out_done_q;
  assign calibrated_o = out_cal_q;

endmodule

/* src/pfd_mem.sv */
// Per-channel value store: one write port, one registered read port.
// Entries read as zero until first written after reset. Uses pfd_pkg.
module pfd_mem #(
  parameter int unsigned Depth = 8,
  parameter int unsigned AddrW = 3
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        we_i,
  input  logic [AddrW-1:0]            waddr_i,
  input  logic [pfd_pkg::DataW-1:0]   wdata_i,
  input  logic                        re_i,
  input  logic [AddrW-1:0]            raddr_i,
  output logic [pfd_pkg::DataW-1:0]   rdata_o
);

  logic [pfd_pkg::DataW-1:0] mem_q [Depth];
  logic [Depth-1:0]          valid_q;
  logic [pfd_pkg::DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= valid_q[raddr_i] ? mem_q[raddr_i] : '0;
    end
  end

  // Valid bits give the all-zero reset without a clearing pass.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (we_i) begin
      valid_q[waddr_i] <= 1'b1;
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sim/tb_ppm_frame_decoder.sv */
// Self-checking testbench for ppm_frame_decoder: a directed table, then random PPM frames,
// checked against an in-bench frame decoder predictor. Depends on pfd_pkg and the RTL.
module tb_ppm_frame_decoder;

  localparam int NumCh = 8;
  localparam int DirRows = 23;
  localparam int CfgRow = 19;
  localparam int ItemsPerPhase = 440;
  localparam int HoldCycles = 400;

  typedef struct packed {
    logic [3:0]         chan;
    logic signed [15:0] value;
    logic               done;
    logic               cal;
  } pulse_report_t;

  typedef enum logic [1:0] {ChkModel, ChkNone, ChkTyped} chk_mode_e;

  typedef struct packed {
    logic          op;
    logic [15:0]   ivl;
    chk_mode_e     mode;
    pulse_report_t rpt;
  } stim_row_t;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        cfg_valid_i;
  logic                        cfg_ready_o;
  logic [pfd_pkg::CfgIdxW-1:0] cfg_index_i;
  logic [pfd_pkg::DataW-1:0]   cfg_data_i;
  logic                        in_valid_i;
  logic                        in_ready_o;
  logic                        operation_i;
  logic [15:0]                 interval_i;
  logic                        out_valid_o;
  logic                        out_ready_i;
  logic [3:0]                  channel_index_o;
  logic signed [15:0]          pulse_value_o;
  logic                        frame_done_o;
  logic                        calibrated_o;

  // Predictor state and its copy of the configuration.
  logic [4:0]          pred_pos;
  logic signed [15:0]  pred_pulse [NumCh];
  logic signed [15:0]  pred_offset [NumCh];
  logic                pred_cal;
  logic [15:0]         pred_center;
  logic [3:0]          pred_uncal;

  pulse_report_t       expected_reports [$];
  stim_row_t           directed_rows [DirRows];
  int                  mismatches;
  int                  items_sent;
  int                  idle_pct;
  int                  stall_pct;
  bit                  hold_req;

  ppm_frame_decoder #(.CHANNELS(NumCh)) DUT (.*);

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  initial begin
    #400000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic decode_request(input logic op, input logic [15:0] ivl,
                                output bit has_rpt, output pulse_report_t rpt);
    logic [15:0]        centered;
    logic signed [15:0] sum;
    logic [4:0]         ch;
    has_rpt = 1'b0;
    rpt = '0;
    if (op == pfd_pkg::OpResync) begin
      pred_pos = pfd_pkg::PosArmed;
    end else if (pred_pos == pfd_pkg::PosArmed) begin
      // The first edge after a resync only marks the start of channel 0.
      pred_pos = '0;
    end else if (pred_pos < NumCh) begin
      ch = pred_pos;
      centered = ivl - pred_center;
      if (ch != {1'b0, pred_uncal}) centered = centered - pred_offset[ch];
      sum = pred_pulse[ch] + centered;
      pred_pulse[ch] = sum / 2;
      pred_pos = ch + 5'd1;
      if (pred_pos == NumCh && !pred_cal) begin
        pred_cal = 1'b1;
        for (int i = 0; i < NumCh; i++)
          if (i != pred_uncal) pred_offset[i] = pred_pulse[i];
      end
      has_rpt = 1'b1;
      rpt.chan = ch[3:0];
      rpt.value = pred_pulse[ch];
      rpt.done = (pred_pos == NumCh);
      rpt.cal = pred_cal;
    end
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance with valid
  // still high, so the caller either offers the next request or lowers it.
  task automatic send_request(input logic op, input logic [15:0] ivl,
                              input chk_mode_e mode, input pulse_report_t typed);
    bit            has_rpt;
    pulse_report_t rpt;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    operation_i = op;
    interval_i = ivl;
    do @(posedge clk_i); while (!in_ready_o);
    decode_request(op, ivl, has_rpt, rpt);
    if (mode == ChkTyped) expected_reports.push_back(typed);
    else if (mode == ChkModel && has_rpt) expected_reports.push_back(rpt);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic write_register(input logic [pfd_pkg::CfgIdxW-1:0] idx,
                                input logic [15:0] data);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == pfd_pkg::RegPulseCenter) pred_center = data;
    else if (idx == pfd_pkg::RegUncalChannel) pred_uncal = data[3:0];
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // The calibration copy can still be running after the last result has left.
  task automatic wait_drained();
    in_valid_i = 1'b0;
    while (expected_reports.size() != 0) @(negedge clk_i);
    repeat (NumCh + 4) @(negedge clk_i);
  endtask

  function automatic logic [15:0] pick_interval();
    logic [15:0] spread;
    spread = 16'($urandom_range(0, 1000));
    case ($urandom_range(0, 5))
      0: return 16'($urandom);
      1: return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
      default: return pred_center + spread - 16'd500;
    endcase
  endfunction

  task automatic send_random_frame();
    int sel;
    int last_edge;
    sel = $urandom_range(0, 99);
    if (sel < 85) begin
      last_edge = NumCh;
      // Now and then a resync cuts the frame short.
      if ($urandom_range(0, 9) == 0) last_edge = $urandom_range(0, NumCh - 1);
      send_request(pfd_pkg::OpResync, 16'($urandom), ChkModel, '0);
      send_request(pfd_pkg::OpEdge, pick_interval(), ChkModel, '0);
      for (int k = 0; k < last_edge; k++)
        send_request(pfd_pkg::OpEdge, pick_interval(), ChkModel, '0);
      if ($urandom_range(0, 4) == 0)
        send_request(pfd_pkg::OpEdge, pick_interval(), ChkModel, '0);
    end else begin
      repeat ($urandom_range(1, 6))
        send_request(1'($urandom_range(0, 1)), pick_interval(), ChkModel, '0);
    end
  endtask

  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ready_i = 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_req = 1'b0;
      end
      out_ready_i = ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    pulse_report_t got;
    pulse_report_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{chan: channel_index_o, value: pulse_value_o, done: frame_done_o,
              cal: calibrated_o};
      if (expected_reports.size() == 0) begin
        $display("%0t: unexpected result ch %0d value %0d done %0b cal %0b", $time,
                 got.chan, $signed(got.value), got.done, got.cal);
        mismatches++;
      end else begin
        want = expected_reports.pop_front();
        if (got.chan !== want.chan || got.value !== want.value ||
            got.done !== want.done || got.cal !== want.cal) begin
          $display("%0t: expected ch %0d value %0d done %0b cal %0b, got ch %0d value %0d done %0b cal %0b",
                   $time, want.chan, $signed(want.value), want.done, want.cal,
                   got.chan, $signed(got.value), got.done, got.cal);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int wait_cycles;
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    operation_i = pfd_pkg::OpResync;
    interval_i = '0;
    mismatches = 0;
    items_sent = 0;
    idle_pct = 0;
    stall_pct = 0;
    hold_req = 1'b0;
    pred_pos = 5'(NumCh);
    pred_cal = 1'b0;
    pred_center = pfd_pkg::PulseCenterRst;
    pred_uncal = pfd_pkg::UncalChannelRst;
    for (int i = 0; i < NumCh; i++) begin
      pred_pulse[i] = '0;
      pred_offset[i] = '0;
    end

    // Stores start at zero, so the first frame reports half the centered interval.
    directed_rows = '{
      '{pfd_pkg::OpEdge,   16'd1500,  ChkNone,  '0},
      '{pfd_pkg::OpResync, 16'd0,     ChkNone,  '0},
      '{pfd_pkg::OpEdge,   16'd777,   ChkNone,  '0},
      '{pfd_pkg::OpEdge,   16'd1500,  ChkTyped, '{4'd0, 16'sd0,      1'b0, 1'b0}},
      '{pfd_pkg::OpEdge,   16'hFFFF,  ChkTyped, '{4'd1, -16'sd750,   1'b0, 1'b0}},
      '{pfd_pkg::OpEdge,   16'd0,     ChkTyped, '{4'd2, -16'sd750,   1'b0, 1'b0}},
      '{pfd_pkg::OpEdge,   16'd1501,  ChkTyped, '{4'd3, 16'sd0,      1'b0, 1'b0}},
      '{pfd_pkg::OpEdge,   16'd1499,  ChkTyped, '{4'd4, 16'sd0,      1'b0, 1'b0}},
      '{pfd_pkg::OpEdge,   16'd34267, ChkTyped, '{4'd5, 16'sd16383,  1'b0, 1'b0}},
      '{pfd_pkg::OpEdge,   16'd34268, ChkTyped, '{4'd6, -16'sd16384, 1'b0, 1'b0}},
      '{pfd_pkg::OpEdge,   16'd1502,  ChkTyped, '{4'd7, 16'sd1,      1'b1, 1'b1}},
      '{pfd_pkg::OpEdge,   16'd1500,  ChkNone,  '0},
      '{pfd_pkg::OpResync, 16'hFFFF,  ChkNone,  '0},
      '{pfd_pkg::OpEdge,   16'd42,    ChkNone,  '0},
      '{pfd_pkg::OpEdge,   16'd1500,  ChkModel, '0},
      '{pfd_pkg::OpEdge,   16'd2000,  ChkModel, '0},
      '{pfd_pkg::OpResync, 16'd0,     ChkNone,  '0},
      '{pfd_pkg::OpEdge,   16'd0,     ChkNone,  '0},
      '{pfd_pkg::OpEdge,   16'd3000,  ChkModel, '0},
      '{pfd_pkg::OpResync, 16'd0,     ChkNone,  '0},
      '{pfd_pkg::OpEdge,   16'd0,     ChkNone,  '0},
      '{pfd_pkg::OpEdge,   16'hFFFF,  ChkModel, '0},
      '{pfd_pkg::OpEdge,   16'h0000,  ChkModel, '0}
    };

    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int r = 0; r < DirRows; r++) begin
      if (r == CfgRow) begin
        // Largest center and an uncalibrated channel index past the last channel.
        wait_drained();
        write_register(pfd_pkg::RegPulseCenter, 16'hFFFF);
        write_register(pfd_pkg::RegUncalChannel, 16'h000F);
      end
      send_request(directed_rows[r].op, directed_rows[r].ivl, directed_rows[r].mode,
                   directed_rows[r].rpt);
    end

    for (int ph = 0; ph < 4; ph++) begin
      int phase_end;
      wait_drained();
      case (ph)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
          write_register(pfd_pkg::RegPulseCenter, 16'($urandom_range(800, 2200)));
          write_register(pfd_pkg::RegUncalChannel, 16'(NumCh - 1));
          hold_req = 1'b1;
        end
        1: begin
          idle_pct = 54;
          stall_pct = 0;
          write_register(pfd_pkg::RegPulseCenter, 16'h0000);
          write_register(pfd_pkg::RegUncalChannel, 16'h0000);
        end
        2: begin
          idle_pct = 0;
          stall_pct = 54;
          write_register(pfd_pkg::RegPulseCenter, 16'hFFFF);
          write_register(pfd_pkg::RegUncalChannel, {12'($urandom), 4'hF});
        end
        default: begin
          idle_pct = 36;
          stall_pct = 36;
          write_register(pfd_pkg::RegPulseCenter, pfd_pkg::PulseCenterRst);
          write_register(pfd_pkg::RegUncalChannel, {12'h000, pfd_pkg::UncalChannelRst});
        end
      endcase
      phase_end = items_sent + ItemsPerPhase;
      while (items_sent < phase_end) send_random_frame();
    end

    in_valid_i = 1'b0;
    wait_cycles = 0;
    while (expected_reports.size() != 0 && wait_cycles < 5000) begin
      @(negedge clk_i);
      wait_cycles++;
    end
    repeat (NumCh + 4) @(negedge clk_i);
    if (expected_reports.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_reports.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
